### sv/rosl_pkg.sv
package rosl_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned REREF_W  = 3;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned STEP_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned BYTES_W  = 16;

    localparam int unsigned MAX_ENTRIES_DEF   = 32;
    localparam int unsigned SLOT_OVERHEAD_DEF = 4;
    localparam logic [SIZE_W-1:0] CAPACITY_RESET = 16'd4096;
    localparam logic [REREF_W-1:0] RR_MAX = 3'd7;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_DROP   = 3'd2,
        CMD_INCR   = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_PAST    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DROP,
        S_REPORT
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_INCR
    } t_cell_op;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [REREF_W-1:0] reref;
    } t_entry;

    typedef struct packed {
        t_cell_op          op;
        t_entry            new_entry;
        logic [STEP_W-1:0] step;
    } t_cell_ctrl;

endpackage

### sv/rosl_if.sv
interface rosl_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] payload_size;
    logic [2:0]  reref_value;
    logic [4:0]  slot_position;
    logic [2:0]  step_amount;

    modport source (output valid, cmd, payload_size, reref_value, slot_position,
                    step_amount, input ready);
    modport sink   (input valid, cmd, payload_size, reref_value, slot_position,
                    step_amount, output ready);
endinterface

interface rosl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        entry_valid;
    logic [4:0]  out_position;
    logic [15:0] out_size;
    logic [2:0]  out_reref;
    logic [5:0]  count_now;
    logic [15:0] bytes_used;

    modport source (output valid, status, entry_valid, out_position, out_size, out_reref,
                    count_now, bytes_used, input ready);
    modport sink   (input valid, status, entry_valid, out_position, out_size, out_reref,
                    count_now, bytes_used, output ready);
endinterface

interface rosl_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] bucket_capacity;

    modport source (output valid, bucket_capacity, input ready);
    modport sink   (input valid, bucket_capacity, output ready);
endinterface

### sv/rrip_ordered_slot_table_core.sv
// Ordered slot table: a bucket of slot headers (payload size and a 3-bit
// re-reference value) kept in descending re-reference order.
// Channels: i_in carries one command transaction (allocate, remove at a
// position, remove through a position, increment, read); o_out returns exactly
// one result transaction per command; i_cfg writes the bucket capacity and is
// ready whenever reset is released. Capacity is meant to be written only while
// the table is idle.
// Timing: a command is accepted only in the idle state. It passes through
// execute, then report, where the result is loaded into the output register
// and the sequencer returns to idle to take the next command. Remove-through
// goes from execute into a drain state that takes one entry per cycle out of
// cell zero, position + 1 entries in all, before report. For the other
// commands every cell of the chain updates in the execute cycle itself.
// Reset clears the fill count, the byte count, the sequencer and the output
// valid, and loads the capacity with 4096. Neither channel is ready while reset
// is held. Cell contents are not cleared; entries past the fill count are
// never reported.
// If the receiver stalls, the finished result waits in the output register and
// the report state holds until the register frees up; no result is dropped.
module rrip_ordered_slot_table_core #(
    parameter int unsigned MAX_ENTRIES   = rosl_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned SLOT_OVERHEAD = rosl_pkg::SLOT_OVERHEAD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rosl_in_if.sink         i_in,
    rosl_out_if.source      o_out,
    rosl_cfg_if.sink        i_cfg
);
    import rosl_pkg::*;

    // Index and count widths follow from the table depth; the compare width is the larger of count and position width.
    localparam int unsigned IW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;
    localparam int unsigned NW = SIZE_W + 2;

    t_state                r_state, n_state;
    logic [CMD_W-1:0]      r_cmd;
    logic [SIZE_W-1:0]     r_size;
    logic [REREF_W-1:0]    r_rr;
    logic [POS_W-1:0]      r_pos;
    logic [STEP_W-1:0]     r_step;
    logic [SIZE_W-1:0]     r_cap;
    logic [CW-1:0]         r_count, n_count;
    logic [BYTES_W-1:0]    r_bytes, n_bytes;
    logic [CW-1:0]         r_left, n_left;
    t_status               r_status, n_status;
    logic                  r_rep_valid, n_rep_valid;
    logic [IW-1:0]         r_rep_idx, n_rep_idx;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic                  r_out_entry_valid;
    logic [POS_W-1:0]      r_out_position;
    logic [SIZE_W-1:0]     r_out_size;
    logic [REREF_W-1:0]    r_out_reref;
    logic [COUNT_W-1:0]    r_out_count;
    logic [BYTES_W-1:0]    r_out_bytes;

    logic                  w_accept;
    logic                  w_out_free;
    t_cell_ctrl            w_ctrl;
    logic [XW-1:0]         w_cell_pos;
    logic [XW-1:0]         w_pos_x;
    logic [XW-1:0]         w_total_x;
    logic                  w_past;
    t_entry                w_cells [0:MAX_ENTRIES-1];
    logic [MAX_ENTRIES-1:0] w_lt;
    logic [MAX_ENTRIES-1:0] w_before;
    logic [IW-1:0]         w_ins_idx;
    logic [IW-1:0]         w_rd_idx;
    t_entry                w_rd;
    logic [NW-1:0]         w_need;
    logic                  w_full;
    logic                  w_nospace;

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && i_rst_n;
    assign i_cfg.ready = i_rst_n;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_pos_x   = XW'(r_pos);
    assign w_total_x = XW'(r_count);
    assign w_past    = (w_pos_x >= w_total_x);

    // The chain of cells: each cell sees its left and right neighbor.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        rosl_cell #(
            .IDX (g),
            .XW  (XW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_pos_x   (w_cell_pos),
            .i_total_x (w_total_x),
            .i_left    (w_cells[(g == 0) ? 0 : g - 1]),
            .i_right   (w_cells[(g == MAX_ENTRIES - 1) ? g : g + 1]),
            .i_before  (w_before[g]),
            .o_entry   (w_cells[g]),
            .o_lt      (w_lt[g])
        );
    end

    // The insert point is the first cell whose value is lower than the new one
    // or that lies at the fill level.
    rosl_prefix #(
        .N (MAX_ENTRIES)
    ) u_prefix (
        .i_flag   (w_lt),
        .o_before (w_before)
    );

    always_comb begin
        w_ins_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_lt[i] && !w_before[i]) begin
                w_ins_idx = w_ins_idx | IW'(i);
            end
        end
    end

    // One read port into the chain: the target position while executing,
    // the reported position afterwards.
    assign w_rd_idx = (r_state == S_EXEC) ? IW'(r_pos) : r_rep_idx;

    always_comb begin
        w_rd = w_cells[0];
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (IW'(i) == w_rd_idx) begin
                w_rd = w_cells[i];
            end
        end
    end

    assign w_need    = NW'(r_size) + NW'(SLOT_OVERHEAD);
    assign w_full    = (r_count == CW'(MAX_ENTRIES));
    assign w_nospace = (NW'(r_bytes) + w_need) > NW'(r_cap);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_bytes     = r_bytes;
        n_left      = r_left;
        n_status    = r_status;
        n_rep_valid = r_rep_valid;
        n_rep_idx   = r_rep_idx;
        w_cell_pos  = w_pos_x;
        w_ctrl.op   = CELL_HOLD;
        w_ctrl.new_entry.size  = r_size;
        w_ctrl.new_entry.reref = r_rr;
        w_ctrl.step = r_step;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_REPORT;
                n_status    = ST_OK;
                n_rep_valid = 1'b0;
                n_rep_idx   = IW'(r_pos);
                if (r_cmd == CMD_ALLOC) begin
                    if (w_full || w_nospace) begin
                        n_status = ST_NOSPACE;
                    end else begin
                        w_ctrl.op   = CELL_INSERT;
                        n_count     = r_count + 1'b1;
                        n_bytes     = r_bytes + BYTES_W'(w_need);
                        n_rep_valid = 1'b1;
                        n_rep_idx   = w_ins_idx;
                    end
                end else if (r_cmd > CMD_READ) begin
                    n_status = ST_OK;
                end else if (w_past) begin
                    n_status = ST_PAST;
                end else begin
                    case (r_cmd)
                        CMD_REMOVE: begin
                            w_ctrl.op   = CELL_SHIFT;
                            n_count     = r_count - 1'b1;
                            n_bytes     = r_bytes - BYTES_W'(w_rd.size)
                                          - BYTES_W'(SLOT_OVERHEAD);
                            n_rep_valid = (w_pos_x < XW'(r_count - 1'b1));
                        end
                        CMD_DROP: begin
                            // Drain position + 1 entries out of the head cell.
                            n_left  = CW'(r_pos) + 1'b1;
                            n_state = S_DROP;
                        end
                        CMD_INCR: begin
                            w_ctrl.op   = CELL_INCR;
                            n_rep_valid = 1'b1;
                        end
                        CMD_READ: begin
                            n_rep_valid = 1'b1;
                        end
                        default: begin
                            n_rep_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_DROP: begin
                w_cell_pos = '0;
                w_ctrl.op  = CELL_SHIFT;
                n_count    = r_count - 1'b1;
                n_bytes    = r_bytes - BYTES_W'(w_cells[0].size) - BYTES_W'(SLOT_OVERHEAD);
                n_left     = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_bytes     <= '0;
            r_cap       <= CAPACITY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_bytes <= n_bytes;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.bucket_capacity;
            end
            if (r_state == S_REPORT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left      <= n_left;
        r_status    <= n_status;
        r_rep_valid <= n_rep_valid;
        r_rep_idx   <= n_rep_idx;
        if (w_accept) begin
            r_cmd  <= i_in.cmd;
            r_size <= i_in.payload_size;
            r_rr   <= i_in.reref_value;
            r_pos  <= i_in.slot_position;
            r_step <= i_in.step_amount;
        end
        if (r_state == S_REPORT && w_out_free) begin
            r_out_status      <= r_status;
            r_out_entry_valid <= r_rep_valid;
            r_out_position    <= r_rep_valid ? POS_W'(r_rep_idx) : '0;
            r_out_size        <= r_rep_valid ? w_rd.size : '0;
            r_out_reref       <= r_rep_valid ? w_rd.reref : '0;
            r_out_count       <= COUNT_W'(r_count);
            r_out_bytes       <= r_bytes;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.entry_valid  = r_out_entry_valid;
    assign o_out.out_position = r_out_position;
    assign o_out.out_size     = r_out_size;
    assign o_out.out_reref    = r_out_reref;
    assign o_out.count_now    = r_out_count;
    assign o_out.bytes_used   = r_out_bytes;

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("fill count exceeds table depth");

    // An accepted command always moves the sequencer into execute.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_EXEC)
        else $error("accepted command did not enter execute");

    // Each drain cycle takes exactly one entry off the table.
    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DROP |=> r_count == $past(r_count) - 1'b1)
        else $error("drain cycle did not remove one entry");

    // A report is loaded only into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid && $stable(r_out_bytes)
                                          && $stable(r_out_status))
        else $error("stalled result was overwritten");
endmodule

### sv/rosl_prefix.sv
module rosl_prefix #(
    parameter int unsigned N = 32
) (
    input  logic [N-1:0] i_flag,
    output logic [N-1:0] o_before
);
    // Log-depth parallel prefix OR; o_before[i] is set when any flag below i is set.
    localparam int unsigned LV = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] w_lvl [0:LV];

    assign w_lvl[0] = i_flag;

    for (genvar k = 0; k < LV; k++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << k)) begin : g_or
                assign w_lvl[k+1][i] = w_lvl[k][i] | w_lvl[k][i-(1<<k)];
            end else begin : g_pass
                assign w_lvl[k+1][i] = w_lvl[k][i];
            end
        end
    end

    assign o_before = {w_lvl[LV][N-2:0], 1'b0};
endmodule

### sv/rosl_cell.sv
module rosl_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned XW  = 6
) (
    input  logic                i_clk,
    input  rosl_pkg::t_cell_ctrl i_ctrl,
    input  logic [XW-1:0]       i_pos_x,
    input  logic [XW-1:0]       i_total_x,
    input  rosl_pkg::t_entry    i_left,
    input  rosl_pkg::t_entry    i_right,
    input  logic                i_before,
    output rosl_pkg::t_entry    o_entry,
    output logic                o_lt
);
    import rosl_pkg::*;

    logic [XW-1:0]    w_idx;
    logic [REREF_W:0] w_sum;
    t_entry           r_entry;
    t_entry           n_entry;

    assign w_idx   = XW'(IDX);
    assign o_entry = r_entry;

    // A cell at or past the fill level counts as a stopping point for the insert search.
    assign o_lt = (w_idx >= i_total_x) || (r_entry.reref < i_ctrl.new_entry.reref);

    always_comb begin
        w_sum   = {1'b0, r_entry.reref} + {1'b0, i_ctrl.step};
        n_entry = r_entry;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (i_before) begin
                    n_entry = i_left;
                end else if (o_lt) begin
                    n_entry = i_ctrl.new_entry;
                end
            end
            CELL_SHIFT: begin
                if (w_idx >= i_pos_x) begin
                    n_entry = i_right;
                end
            end
            CELL_INCR: begin
                if (w_idx == i_pos_x) begin
                    n_entry.reref = (w_sum > {1'b0, RR_MAX}) ? RR_MAX : w_sum[REREF_W-1:0];
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end
endmodule
